[hw/rtl/nmfc_pkg.sv]
// ----------------------------------------------------------------------------
// nmfc_pkg: shared types, constants and functions of the noise mask curve
// Fixed-point constants, register indexes, curve codes, pipeline stage types
// and the elaboration-time square-root chain for the exp2 factors.
// ----------------------------------------------------------------------------
package nmfc_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q  = 17'(1 << FRAC_BITS);
    localparam logic [16:0] HALF_Q = 17'(1 << (FRAC_BITS - 1));
    localparam logic [16:0] MIN_WIDTH = 17'd7;
    localparam logic [16:0] GAIN_MIN  = 17'd66;
    localparam logic [16:0] GAIN_MAX  = 17'd65470;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [9:0]  EXP_MAX_SHIFT = 10'd40;

    // Iteration counts of the pipelined units
    localparam int DIV_STEPS  = 15;
    localparam int LOG2_STEPS = FRAC_BITS;
    localparam int EXP_STEPS  = FRAC_BITS;

    // Register indexes of the config port
    typedef enum logic [2:0] {
        CFG_MASK_INERT   = 3'd0,
        CFG_THRESHOLD    = 3'd1,
        CFG_TRANS_WIDTH  = 3'd2,
        CFG_CURVE_MODE   = 3'd3,
        CFG_GAIN_AMOUNT  = 3'd4,
        CFG_INVERT       = 3'd5,
        CFG_TABLE_COUNT  = 3'd6,
        CFG_TABLE_POINTS = 3'd7
    } t_cfg_idx;

    // Curve selection codes
    typedef enum logic [2:0] {
        MODE_STEP     = 3'd0,
        MODE_LINEAR   = 3'd1,
        MODE_SMOOTH   = 3'd2,
        MODE_SMOOTHER = 3'd3,
        MODE_GAIN     = 3'd4,
        MODE_TABLE    = 3'd5
    } t_curve_mode;

    // One divider stage
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic        sat;
        logic [32:0] rem;
        logic [14:0] quo;
    } t_dv_stage;

    // Sideband carried along the gain path
    typedef struct packed {
        logic        valid;
        logic        lo;
        logic        xzero;
        logic [16:0] alt;
    } t_sb_stage;

    // One exp2 product stage
    typedef struct packed {
        logic [30:0] acc;
        logic [5:0]  sh;
        logic [15:0] f;
        logic        zero;
    } t_ex_stage;

    // Integer square root, digit by digit
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_w;
        int i;
        rem   = v;
        res   = 64'd0;
        bit_w = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (bit_w > rem) bit_w = bit_w >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (bit_w != 64'd0) begin
                if (rem >= res + bit_w) begin
                    rem = rem - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q1.30, each factor the square root of the one before
    function automatic logic [30:0] exp_factor(input int k);
        logic [63:0] c;
        int j;
        c = 64'd1 << 29;
        for (j = 1; j <= EXP_STEPS; j++) begin
            if (j <= k) c = isqrt64(c << 30);
        end
        return c[30:0];
    endfunction

endpackage

[hw/rtl/noise_mask_falloff_curve.sv]
// ----------------------------------------------------------------------------
// noise_mask_falloff_curve: noise sample to mask weight
// Maps a signed Q2.16 noise sample through a band normalization and one of
// six falloff curves to a Q1.16 weight, with optional inversion.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    noise_value [17:0]
//  m_axis    out  m_axis_tvalid/m_axis_tready    mask_weight [16:0]
//  cfg       in   i_cfg_we                       i_cfg_index, i_cfg_wdata
//
// One word enters per cycle while m_axis is not stalled; the path runs through the
// 16-stage band divider, the 17-stage log2 unit and the 16-stage exp2 chain.
// A stall on m_axis freezes all but the gain log2; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module noise_mask_falloff_curve import nmfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [17:0] noise_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] mask_weight
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    localparam int Q_STAGE = LOG2_STEPS + 2;
    localparam int SB_LAST = Q_STAGE + EXP_STEPS;

    // Config registers
    logic        r_mask_inert;
    logic [17:0] r_threshold;
    logic [16:0] r_trans_width;
    logic [2:0]  r_curve_mode;
    logic [16:0] r_gain_amount;
    logic        r_invert;
    logic [2:0]  r_table_count;
    logic [63:0] r_table_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_inert   <= 1'b0;
            r_threshold    <= 18'd0;
            r_trans_width  <= ONE_Q;
            r_curve_mode   <= MODE_LINEAR;
            r_gain_amount  <= HALF_Q;
            r_invert       <= 1'b0;
            r_table_count  <= 3'd0;
            r_table_points <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MASK_INERT:   r_mask_inert   <= i_cfg_wdata[0];
                CFG_THRESHOLD:    r_threshold    <= i_cfg_wdata[17:0];
                CFG_TRANS_WIDTH:  r_trans_width  <= i_cfg_wdata[16:0];
                CFG_CURVE_MODE:   r_curve_mode   <= i_cfg_wdata[2:0];
                CFG_GAIN_AMOUNT:  r_gain_amount  <= i_cfg_wdata[16:0];
                CFG_INVERT:       r_invert       <= i_cfg_wdata[0];
                CFG_TABLE_COUNT:  r_table_count  <= i_cfg_wdata[2:0];
                CFG_TABLE_POINTS: r_table_points <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Config-derived values; user keeps config stable while words are in flight
    logic [16:0] w_eff;
    logic [17:0] div_den;
    logic [16:0] g_clamp;
    logic [16:0] e_in;
    logic [2:0]  tab_n;
    logic        tab_id;

    always_comb begin
        w_eff   = (r_trans_width < MIN_WIDTH) ? MIN_WIDTH : r_trans_width;
        div_den = {w_eff, 1'b0};
        if (r_gain_amount < GAIN_MIN)      g_clamp = GAIN_MIN;
        else if (r_gain_amount > GAIN_MAX) g_clamp = GAIN_MAX;
        else                               g_clamp = r_gain_amount;
        e_in    = ONE_Q - g_clamp;
        tab_n   = (r_table_count > 3'd4) ? 3'd4 : r_table_count;
        tab_id  = (tab_n < 3'd2);
    end

    // Global advance: the whole pipe moves when the output can take a word
    logic r_out_valid;
    logic en;
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage A: difference to threshold, split into sign and magnitude
    logic        r_a_valid;
    logic        r_a_neg;
    logic [17:0] r_a_mag;
    logic [18:0] n_a_diff;
    logic [18:0] n_a_abs;

    always_comb begin
        n_a_diff = {s_axis_tdata[17], s_axis_tdata[17:0]} - {r_threshold[17], r_threshold};
        n_a_abs  = n_a_diff[18] ? (19'd0 - n_a_diff) : n_a_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_a_valid <= 1'b0;
        else if (en)   r_a_valid <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg <= n_a_diff[18];
            r_a_mag <= n_a_abs[17:0];
        end
    end

    // Band divider: saturation check, then one quotient bit per stage
    t_dv_stage   r_dv [0:DIV_STEPS];
    t_dv_stage   n_dv0;
    logic [33:0] dv_num;

    always_comb begin
        dv_num      = {r_a_mag, 16'b0};
        n_dv0.valid = r_a_valid;
        n_dv0.neg   = r_a_neg;
        n_dv0.sat   = (dv_num >= {1'b0, div_den, 15'b0});
        n_dv0.rem   = dv_num[32:0];
        n_dv0.quo   = 15'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_dv[0].valid <= 1'b0;
        else if (en)   r_dv[0] <= n_dv0;
    end

    for (genvar gj = 1; gj <= DIV_STEPS; gj++) begin : g_div
        localparam int SH = DIV_STEPS - gj;
        logic [32:0] den_sh;
        t_dv_stage   n_dv;
        always_comb begin
            den_sh = {15'b0, div_den} << SH;
            n_dv   = r_dv[gj-1];
            if (r_dv[gj-1].rem >= den_sh) begin
                n_dv.rem     = r_dv[gj-1].rem - den_sh;
                n_dv.quo[SH] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_dv[gj].valid <= 1'b0;
            else if (en)   r_dv[gj] <= n_dv;
        end
    end

    // Band position t, clamped to [0, 1.0]
    logic        r_t_valid;
    logic [16:0] r_t;
    logic [16:0] n_t;

    always_comb begin
        if (r_dv[DIV_STEPS].sat)      n_t = r_dv[DIV_STEPS].neg ? 17'd0 : ONE_Q;
        else if (r_dv[DIV_STEPS].neg) n_t = HALF_Q - {2'b0, r_dv[DIV_STEPS].quo};
        else                          n_t = HALF_Q + {2'b0, r_dv[DIV_STEPS].quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_t_valid <= 1'b0;
        else if (en)   r_t_valid <= r_dv[DIV_STEPS].valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_t <= n_t;
    end

    // Gain base: 2t below the midpoint, 2 - 2t above
    logic        t_lo;
    logic [16:0] n_x;
    logic [17:0] x_hi;

    always_comb begin
        t_lo = (r_t < HALF_Q);
        x_hi = 18'd131072 - {r_t, 1'b0};
        n_x  = t_lo ? {r_t[15:0], 1'b0} : x_hi[16:0];
    end

    // Curve stage 1: squares, smootherstep bias, table segment
    logic [16:0] r_c1_t;
    logic [16:0] r_c1_t2;
    logic [19:0] r_c1_b;
    logic [15:0] r_c1_pa;
    logic [16:0] r_c1_diff;
    logic [16:0] r_c1_fr;

    logic [33:0] c1_sq;
    logic [18:0] c1_t6;
    logic [19:0] c1_amag;
    logic [36:0] c1_ta;
    logic [20:0] c1_b;
    logic [18:0] c1_p;
    logic [1:0]  c1_lim;
    logic [1:0]  c1_idx;
    logic [1:0]  c1_idx1;
    logic [17:0] c1_fr;
    logic [15:0] c1_pa;
    logic [15:0] c1_pb;

    always_comb begin
        c1_sq   = {17'b0, r_t} * {17'b0, r_t};
        c1_t6   = {r_t, 2'b0} - {1'b0, r_t, 1'b0} + {r_t, 2'b0} - {r_t, 2'b0}
                  + {1'b0, r_t, 1'b0} + {1'b0, r_t, 1'b0};
        c1_amag = 20'd983040 - {1'b0, c1_t6};
        c1_ta   = {20'b0, r_t} * {17'b0, c1_amag};
        c1_b    = 21'd655360 - c1_ta[36:16];
        c1_p    = 19'(r_t) * 19'(tab_n - 3'd1);
        c1_lim  = 2'(tab_n - 3'd2);
        c1_idx  = (c1_p[17:16] > c1_lim) ? c1_lim : c1_p[17:16];
        c1_idx1 = c1_idx + 2'd1;
        c1_fr   = c1_p[17:0] - {c1_idx, 16'b0};
        c1_pa   = r_table_points[{c1_idx, 4'b0} +: 16];
        c1_pb   = r_table_points[{c1_idx1, 4'b0} +: 16];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_t    <= r_t;
            r_c1_t2   <= c1_sq[32:16];
            r_c1_b    <= c1_b[19:0];
            r_c1_pa   <= c1_pa;
            r_c1_diff <= {1'b0, c1_pb} - {1'b0, c1_pa};
            r_c1_fr   <= c1_fr[16:0];
        end
    end

    // Curve stage 2: smoothstep, cube, table product
    logic [16:0]        r_c2_t;
    logic [16:0]        r_c2_smooth;
    logic [16:0]        r_c2_t3;
    logic [19:0]        r_c2_b;
    logic [15:0]        r_c2_pa;
    logic signed [34:0] r_c2_tprod;

    logic [17:0] c2_m;
    logic [34:0] c2_sp;
    logic [33:0] c2_cube;

    always_comb begin
        c2_m    = 18'd196608 - {r_c1_t, 1'b0};
        c2_sp   = {18'b0, r_c1_t2} * {17'b0, c2_m};
        c2_cube = {17'b0, r_c1_t2} * {17'b0, r_c1_t};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2_t      <= r_c1_t;
            r_c2_smooth <= c2_sp[32:16];
            r_c2_t3     <= c2_cube[32:16];
            r_c2_b      <= r_c1_b;
            r_c2_pa     <= r_c1_pa;
            r_c2_tprod  <= 35'($signed(r_c1_diff)) * 35'($signed({1'b0, r_c1_fr}));
        end
    end

    // Curve stage 3: smootherstep, table result, mode select
    logic [36:0]        c3_sm;
    logic [16:0]        c3_smoother;
    logic [34:0]        c3_tmag;
    logic signed [20:0] c3_tq;
    logic signed [20:0] c3_tab;
    logic [16:0]        c3_table;
    logic [16:0]        n_alt;

    always_comb begin
        c3_sm       = {20'b0, r_c2_t3} * {17'b0, r_c2_b};
        c3_smoother = (c3_sm[36:16] > 21'(ONE_Q)) ? ONE_Q : c3_sm[32:16];
        c3_tmag     = r_c2_tprod[34] ? 35'(-r_c2_tprod) : 35'(r_c2_tprod);
        c3_tq       = r_c2_tprod[34] ? -$signed({2'b0, c3_tmag[34:16]})
                                     : $signed({2'b0, c3_tmag[34:16]});
        c3_tab      = $signed({5'b0, r_c2_pa}) + c3_tq;
        if (c3_tab < 0)                   c3_table = 17'd0;
        else if (c3_tab > 21'sd65536)     c3_table = ONE_Q;
        else                              c3_table = c3_tab[16:0];
        unique case (t_curve_mode'(r_curve_mode))
            MODE_STEP:     n_alt = (r_c2_t < HALF_Q) ? 17'd0 : ONE_Q;
            MODE_SMOOTH:   n_alt = r_c2_smooth;
            MODE_SMOOTHER: n_alt = c3_smoother;
            MODE_TABLE:    n_alt = tab_id ? r_c2_t : c3_table;
            default:       n_alt = r_c2_t;
        endcase
    end

    // Gain exponent from the clamped gain; free-running, relies on user-held config
    logic [20:0] e_mag;
    logic [20:0] x_mag;

    nmfc_log2 u_log2_gain (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_x   (e_in),
        .o_mag (e_mag)
    );

    nmfc_log2 u_log2_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (n_x),
        .o_mag (x_mag)
    );

    // Sideband along the gain path; other curve results join at stage 3
    t_sb_stage r_sb [1:SB_LAST];

    for (genvar gk = 1; gk <= SB_LAST; gk++) begin : g_sb
        t_sb_stage n_sb;
        if (gk == 1) begin : g_first
            always_comb begin
                n_sb.valid = r_t_valid;
                n_sb.lo    = t_lo;
                n_sb.xzero = (n_x == 17'd0);
                n_sb.alt   = r_t;
            end
        end else if (gk == 3) begin : g_join
            always_comb begin
                n_sb     = r_sb[gk-1];
                n_sb.alt = n_alt;
            end
        end else begin : g_pass
            always_comb n_sb = r_sb[gk-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_sb[gk].valid <= 1'b0;
            else if (en)   r_sb[gk] <= n_sb;
        end
    end

    // Exponent times log magnitude
    logic [41:0] q_prod;
    logic [25:0] r_q;

    assign q_prod = {21'b0, e_mag} * {21'b0, x_mag};

    always_ff @(posedge i_clk) begin
        if (en) r_q <= q_prod[41:16];
    end

    // exp2 of the negative fraction: one conditional factor per stage
    t_ex_stage r_ex [1:EXP_STEPS];

    for (genvar gk = 1; gk <= EXP_STEPS; gk++) begin : g_exp
        localparam logic [30:0] FACT = exp_factor(gk);
        t_ex_stage   n_in;
        t_ex_stage   n_ex;
        logic [61:0] prod;
        if (gk == 1) begin : g_first
            always_comb begin
                n_in.acc  = Q30_ONE;
                n_in.sh   = r_q[21:16];
                n_in.f    = r_q[15:0];
                n_in.zero = (r_q[25:16] > EXP_MAX_SHIFT);
            end
        end else begin : g_next
            always_comb n_in = r_ex[gk-1];
        end
        always_comb begin
            prod = {31'b0, n_in.acc} * {31'b0, FACT};
            n_ex = n_in;
            if (n_in.f[EXP_STEPS-gk]) n_ex.acc = prod[60:30];
        end
        always_ff @(posedge i_clk) begin
            if (en) r_ex[gk] <= n_ex;
        end
    end

    // Output: gain assembly, mode select, invert, inert override
    logic [6:0]  o_sh;
    logic [30:0] o_acc;
    logic [16:0] o_pw;
    logic [16:0] o_half;
    logic [16:0] o_gain;
    logic [16:0] o_curve;
    logic [16:0] n_out;
    logic [16:0] r_out_data;

    always_comb begin
        o_sh   = 7'(r_ex[EXP_STEPS].sh) + 7'd14;
        o_acc  = r_ex[EXP_STEPS].acc >> o_sh;
        o_pw   = (r_ex[EXP_STEPS].zero || r_sb[SB_LAST].xzero) ? 17'd0 : o_acc[16:0];
        o_half = {1'b0, o_pw[16:1]};
        o_gain = r_sb[SB_LAST].lo ? o_half : (ONE_Q - o_half);
        o_curve = (r_curve_mode == MODE_GAIN) ? o_gain : r_sb[SB_LAST].alt;
        if (r_mask_inert)  n_out = ONE_Q;
        else if (r_invert) n_out = ONE_Q - o_curve;
        else               n_out = o_curve;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_out_valid <= 1'b0;
        else if (en)   r_out_valid <= r_sb[SB_LAST].valid;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out_data <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_data};

endmodule

[hw/rtl/nmfc_log2.sv]
// ----------------------------------------------------------------------------
// nmfc_log2: pipelined base-2 logarithm magnitude
// For x in (0, 1.0] in Q1.16 gives -log2(x) in Q.16, one fraction bit per
// stage from repeated squaring in Q1.30.
// ----------------------------------------------------------------------------
module nmfc_log2 import nmfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_x,
    output logic [20:0] o_mag
);

    logic [30:0] r_m  [0:LOG2_STEPS];
    logic [4:0]  r_n  [0:LOG2_STEPS];
    logic [15:0] r_fr [0:LOG2_STEPS];

    logic [4:0]  n_msb;
    logic [4:0]  n_shift;

    // Normalize: find the top set bit and shift the mantissa to [1, 2)
    always_comb begin
        n_msb = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (i_x[i]) n_msb = 5'(i);
        end
        n_shift = 5'd16 - n_msb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= {i_x, 14'b0} << n_shift;
            r_n[0]  <= n_shift;
            r_fr[0] <= 16'd0;
        end
    end

    // One squaring per stage yields one fraction bit
    for (genvar gj = 1; gj <= LOG2_STEPS; gj++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] sq_hi;
        always_comb begin
            sq    = {31'b0, r_m[gj-1]} * {31'b0, r_m[gj-1]};
            sq_hi = sq[61:30];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[gj]  <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
                r_n[gj]  <= r_n[gj-1];
                r_fr[gj] <= {r_fr[gj-1][14:0], sq_hi[31]};
            end
        end
    end

    assign o_mag = {r_n[LOG2_STEPS], 16'b0} - {5'b0, r_fr[LOG2_STEPS]};

endmodule

[hw/rtl/nmfc_checker.sv]
// ----------------------------------------------------------------------------
// nmfc_checker: port-level checks of the noise mask curve
// Watches the stream ports for reset, back-pressure and result range.
// ----------------------------------------------------------------------------
module nmfc_checker import nmfc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Held word stays put under back-pressure
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Input side moves exactly when the output side frees up
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output");

    // Weight stays within [0, 1.0] and the pad bits are zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= ONE_Q) && (m_axis_tdata[23:17] == 7'd0))
        else $error("mask weight out of range");

endmodule

bind noise_mask_falloff_curve nmfc_checker u_nmfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
